// ===== rtl/assert_macros.svh =====
// assertion macros used by the divider rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is active
`define SIDU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked assertion that a condition never holds
`define SIDU_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/sidu_pkg.sv =====
// package: widths and sequencer states of the signed integer divider
`timescale 1ns / 1ps

package sidu_pkg;

    // operand and result width
    localparam int WIDTH = 32;
    // bit counter width for the divide loop
    localparam int CNT_W = $clog2(WIDTH);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEG_A,
        ST_NEG_B,
        ST_DIV,
        ST_FIX_Q,
        ST_FIX_R,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/signed_integer_divider_unit.sv =====
// signed integer divider, truncating toward zero, one shared adder under a sequencer
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_dividend, i_divisor
//  out     | output    | o_out_valid / i_out_stall | o_out_quotient, o_out_remainder,
//          |           |                           | o_out_div_by_zero, o_out_overflow
//
// after acceptance the sequencer takes the operand magnitudes (ST_NEG_A, ST_NEG_B),
// forms one quotient bit per cycle in ST_DIV, fixes the quotient and remainder signs
// (ST_FIX_Q, ST_FIX_R) and loads the output register in ST_DONE; all steps but the
// last go through the one shared adder. the next transaction is accepted back in idle.
// o_in_stall is high from acceptance until the sequencer is back in idle.
// a result stalled at the output holds the sequencer in its last state; a new
// transaction is accepted while the previous result still waits to be taken.
// reset is synchronous, active low, and clears the sequencer and output valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module signed_integer_divider_unit import sidu_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [WIDTH-1:0] i_dividend,
    input  logic signed [WIDTH-1:0] i_divisor,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [WIDTH-1:0] o_out_quotient,
    output logic signed [WIDTH-1:0] o_out_remainder,
    output logic                    o_out_div_by_zero,
    output logic                    o_out_overflow
);

    localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] ALL_ONES = {WIDTH{1'b1}};
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WIDTH - 1);

    t_state           r_state, n_state;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_div, n_div;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_neg_a, n_neg_a;
    logic             r_neg_b, n_neg_b;
    logic             r_dz, n_dz;
    logic             r_ovf, n_ovf;

    logic             r_out_valid, n_out_valid;
    logic [WIDTH-1:0] r_out_quo, n_out_quo;
    logic [WIDTH-1:0] r_out_rem, n_out_rem;
    logic             r_out_dz, n_out_dz;
    logic             r_out_ovf, n_out_ovf;

    // shared adder: x + ~y + 1
    logic [WIDTH-1:0] u_x;
    logic [WIDTH-1:0] u_y;
    logic [WIDTH:0]   u_sum;
    logic [WIDTH-1:0] partial;
    logic             in_acc;
    logic             out_free;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign partial  = {r_rem[WIDTH-2:0], r_quo[WIDTH-1]};
    assign u_sum    = {1'b0, u_x} + {1'b0, ~u_y} + {{WIDTH{1'b0}}, 1'b1};

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_div     <= n_div;
        r_cnt     <= n_cnt;
        r_neg_a   <= n_neg_a;
        r_neg_b   <= n_neg_b;
        r_dz      <= n_dz;
        r_ovf     <= n_ovf;
        r_out_quo <= n_out_quo;
        r_out_rem <= n_out_rem;
        r_out_dz  <= n_out_dz;
        r_out_ovf <= n_out_ovf;
    end

    // adder operand selection
    always_comb begin
        u_x = '0;
        u_y = '0;
        case (r_state)
            ST_NEG_A: u_y = r_quo;
            ST_NEG_B: u_y = r_div;
            ST_DIV: begin
                u_x = partial;
                u_y = r_div;
            end
            ST_FIX_Q: u_y = r_quo;
            ST_FIX_R: u_y = r_rem;
            default: begin
                u_x = '0;
                u_y = '0;
            end
        endcase
    end

    // next state and datapath
    always_comb begin
        n_state     = r_state;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_div       = r_div;
        n_cnt       = r_cnt;
        n_neg_a     = r_neg_a;
        n_neg_b     = r_neg_b;
        n_dz        = r_dz;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_quo   = r_out_quo;
        n_out_rem   = r_out_rem;
        n_out_dz    = r_out_dz;
        n_out_ovf   = r_out_ovf;
        o_in_stall  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (in_acc) begin
                    n_quo   = i_dividend;
                    n_div   = i_divisor;
                    n_rem   = '0;
                    n_neg_a = i_dividend[WIDTH-1];
                    n_neg_b = i_divisor[WIDTH-1];
                    n_dz    = (i_divisor == '0);
                    n_ovf   = (i_dividend == MOST_NEG) && (i_divisor == ALL_ONES);
                    n_state = ST_NEG_A;
                end
            end
            // dividend magnitude
            ST_NEG_A: begin
                if (r_neg_a) begin
                    n_quo = u_sum[WIDTH-1:0];
                end
                n_state = ST_NEG_B;
            end
            // divisor magnitude
            ST_NEG_B: begin
                if (r_neg_b) begin
                    n_div = u_sum[WIDTH-1:0];
                end
                n_cnt   = LAST_BIT;
                n_state = ST_DIV;
            end
            // restoring step, one quotient bit per cycle
            ST_DIV: begin
                n_rem = u_sum[WIDTH] ? u_sum[WIDTH-1:0] : partial;
                n_quo = {r_quo[WIDTH-2:0], u_sum[WIDTH]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_FIX_Q;
                end
            end
            // quotient sign
            ST_FIX_Q: begin
                if (r_neg_a != r_neg_b) begin
                    n_quo = u_sum[WIDTH-1:0];
                end
                n_state = ST_FIX_R;
            end
            // remainder takes the dividend sign
            ST_FIX_R: begin
                if (r_neg_a) begin
                    n_rem = u_sum[WIDTH-1:0];
                end
                n_state = ST_DONE;
            end
            // hand the result to the output register
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_quo   = r_dz ? '0 : r_quo;
                    n_out_rem   = r_dz ? '0 : r_rem;
                    n_out_dz    = r_dz;
                    n_out_ovf   = r_ovf;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_quotient    = r_out_quo;
    assign o_out_remainder   = r_out_rem;
    assign o_out_div_by_zero = r_out_dz;
    assign o_out_overflow    = r_out_ovf;

    // checks
    `SIDU_ASSERT(a_dz_zero, (o_out_valid && o_out_div_by_zero) |-> (o_out_quotient == '0 && o_out_remainder == '0), "divide by zero result not zero")
    `SIDU_NEVER(a_flags_excl, o_out_valid && o_out_div_by_zero && o_out_overflow, "both flags set")
    `SIDU_ASSERT(a_accept_start, (i_in_valid && !o_in_stall) |=> (r_state == ST_NEG_A), "accepted transaction did not start")
    `SIDU_ASSERT(a_div_end, (r_state == ST_DIV && r_cnt == '0) |=> (r_state == ST_FIX_Q), "divide loop did not finish")

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the signed integer divider unit
`timescale 1ns / 1ps

module tb import sidu_pkg::*; ();

    localparam int CLK_HALF    = 5;
    localparam int N_DIRECTED  = 24;
    localparam int N_RANDOM    = 550;
    localparam int N_QUIET     = 60;
    localparam int DRAIN_WAIT  = WIDTH + 16;

    localparam logic signed [WIDTH-1:0] MIN_V = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic signed [WIDTH-1:0] MAX_V = {1'b0, {(WIDTH-1){1'b1}}};

    // one division outcome as the block reports it
    typedef struct packed {
        logic signed [WIDTH-1:0] quo;
        logic signed [WIDTH-1:0] rem;
        logic                    dbz;
        logic                    ovf;
    } t_div_outcome;

    // one stimulus row, with an optional hand-written outcome
    typedef struct packed {
        logic signed [WIDTH-1:0] dividend;
        logic signed [WIDTH-1:0] divisor;
        logic                    fixed;
        t_div_outcome            res;
    } t_div_vector;

    // directed rows: divide by zero, most negative by minus one, extremes, sign mixes
    localparam t_div_vector DIRECTED_TAB [N_DIRECTED] = '{
        '{0,     0,          1'b1, '{0, 0, 1'b1, 1'b0}},
        '{5,     0,          1'b1, '{0, 0, 1'b1, 1'b0}},
        '{MIN_V, 0,          1'b1, '{0, 0, 1'b1, 1'b0}},
        '{-1,    0,          1'b1, '{0, 0, 1'b1, 1'b0}},
        '{MIN_V, -1,         1'b1, '{MIN_V, 0, 1'b0, 1'b1}},
        '{MAX_V, 1,          1'b1, '{MAX_V, 0, 1'b0, 1'b0}},
        '{MAX_V, -1,         1'b1, '{-MAX_V, 0, 1'b0, 1'b0}},
        '{MIN_V, 1,          1'b1, '{MIN_V, 0, 1'b0, 1'b0}},
        '{MIN_V, MIN_V,      1'b1, '{1, 0, 1'b0, 1'b0}},
        '{MAX_V, MAX_V,      1'b1, '{1, 0, 1'b0, 1'b0}},
        '{MAX_V, MIN_V,      1'b1, '{0, MAX_V, 1'b0, 1'b0}},
        '{MIN_V, MAX_V,      1'b1, '{-1, -1, 1'b0, 1'b0}},
        '{7,     2,          1'b1, '{3, 1, 1'b0, 1'b0}},
        '{-7,    2,          1'b1, '{-3, -1, 1'b0, 1'b0}},
        '{7,     -2,         1'b1, '{-3, 1, 1'b0, 1'b0}},
        '{-7,    -2,         1'b1, '{3, -1, 1'b0, 1'b0}},
        '{0,     MIN_V,      1'b1, '{0, 0, 1'b0, 1'b0}},
        '{0,     -1,         1'b1, '{0, 0, 1'b0, 1'b0}},
        '{1,     MAX_V,      1'b1, '{0, 1, 1'b0, 1'b0}},
        '{-1,    MIN_V,      1'b1, '{0, -1, 1'b0, 1'b0}},
        '{MIN_V, 2,          1'b1, '{MIN_V >>> 1, 0, 1'b0, 1'b0}},
        '{MIN_V, -2,         1'b1, '{-(MIN_V >>> 1), 0, 1'b0, 1'b0}},
        '{12345678, 1000,    1'b0, '{0, 0, 1'b0, 1'b0}},
        '{-100,  7,          1'b0, '{0, 0, 1'b0, 1'b0}}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic signed [WIDTH-1:0] i_dividend;
    logic signed [WIDTH-1:0] i_divisor;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic signed [WIDTH-1:0] o_out_quotient;
    logic signed [WIDTH-1:0] o_out_remainder;
    logic                    o_out_div_by_zero;
    logic                    o_out_overflow;

    t_div_vector  cur_vector;
    t_div_outcome owed_divisions [$];
    int           mismatch_cnt = 0;
    int           results_seen = 0;
    bit           quiet = 1'b0;
    int           stall_left = 0;

    signed_integer_divider_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_dividend        (i_dividend),
        .i_divisor         (i_divisor),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_quotient    (o_out_quotient),
        .o_out_remainder   (o_out_remainder),
        .o_out_div_by_zero (o_out_div_by_zero),
        .o_out_overflow    (o_out_overflow)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // truncating division on magnitudes, sign fixup afterwards
    function automatic t_div_outcome predict_division(logic [WIDTH-1:0] a,
                                                      logic [WIDTH-1:0] b);
        t_div_outcome    res;
        logic            neg_a;
        logic            neg_b;
        logic [WIDTH-1:0] mag_a;
        logic [WIDTH-1:0] mag_b;
        logic [WIDTH-1:0] q;
        logic [WIDTH-1:0] r;
        res = '0;
        if (b == '0) begin
            res.dbz = 1'b1;
            return res;
        end
        neg_a = a[WIDTH-1];
        neg_b = b[WIDTH-1];
        mag_a = neg_a ? -a : a;
        mag_b = neg_b ? -b : b;
        q = mag_a / mag_b;
        r = mag_a % mag_b;
        res.quo = (neg_a != neg_b) ? -q : q;
        res.rem = neg_a ? -r : r;
        res.ovf = (a == MIN_V) && (b == '1);
        return res;
    endfunction

    // operand mix: corner values, small numbers, scaled and full-range randoms
    function automatic logic signed [WIDTH-1:0] pick_operand();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 7))
                    0: return 0;
                    1: return 1;
                    2: return -1;
                    3: return MIN_V;
                    4: return MAX_V;
                    5: return MIN_V + 1;
                    6: return 2;
                    default: return -2;
                endcase
            end
            1, 2: return $signed($urandom_range(0, 40)) - 20;
            3: return $signed(raw[WIDTH-1:0]) >>> $urandom_range(0, WIDTH - 1);
            default: return raw[WIDTH-1:0];
        endcase
    endfunction

    task automatic flag_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    // hold one transaction on the input until the block takes it
    task automatic drive_division(t_div_vector vec);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 17);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_dividend = vec.dividend;
        i_divisor  = vec.divisor;
        cur_vector = vec;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // output stall in random bursts, no new burst starts once the quiet stretch begins
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall = 1'b1;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            i_out_stall = 1'b1;
            stall_left  = $urandom_range(0, 16);
        end else begin
            i_out_stall = 1'b0;
        end
    end

    // record the outcome owed for every accepted transaction
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            owed_divisions.push_back(cur_vector.fixed ? cur_vector.res
                                     : predict_division(i_dividend, i_divisor));
    end

    // compare every accepted result with the oldest owed outcome
    always @(posedge i_clk) begin
        t_div_outcome exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_divisions.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with nothing owed",
                                        results_seen));
            end else begin
                exp_res = owed_divisions.pop_front();
                if (o_out_quotient !== exp_res.quo)
                    flag_mismatch($sformatf("result %0d quotient %0d, expected %0d",
                                            results_seen, o_out_quotient, exp_res.quo));
                if (o_out_remainder !== exp_res.rem)
                    flag_mismatch($sformatf("result %0d remainder %0d, expected %0d",
                                            results_seen, o_out_remainder, exp_res.rem));
                if (o_out_div_by_zero !== exp_res.dbz)
                    flag_mismatch($sformatf("result %0d div_by_zero %b, expected %b",
                                            results_seen, o_out_div_by_zero, exp_res.dbz));
                if (o_out_overflow !== exp_res.ovf)
                    flag_mismatch($sformatf("result %0d overflow %b, expected %b",
                                            results_seen, o_out_overflow, exp_res.ovf));
            end
            results_seen++;
        end
    end

    // main sequence: reset, directed table, random operands, drain
    initial begin
        t_div_vector vec;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_dividend = '0;
        i_divisor  = '0;
        cur_vector = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            drive_division(DIRECTED_TAB[i]);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - N_QUIET)
                quiet = 1'b1;
            vec          = '0;
            vec.dividend = pick_operand();
            vec.divisor  = pick_operand();
            drive_division(vec);
        end
        i_in_valid = 1'b0;

        while (owed_divisions.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (owed_divisions.size() == 0 && mismatch_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // run limit, well above the slowest legal run
    initial begin
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sidu_pkg.sv
rtl/signed_integer_divider_unit.sv
tb/sv/tb.sv
